// ===== rtl/vector_rotate_xor_hash_mod_top_defines.svh =====
// Assertion macros shared by the hash block.
`ifndef VECTOR_ROTATE_XOR_HASH_MOD_TOP_DEFINES_SVH
`define VECTOR_ROTATE_XOR_HASH_MOD_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VRXH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VRXH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vrxh_pkg.sv =====
// Package: widths, constants and shared types of the rotate-xor hash block.
package vrxh_pkg;

    localparam int ELEM_W         = 32;
    localparam int CAP_W          = 31;
    localparam int BUCKET_W       = 31;
    localparam int DEF_WORD_WIDTH = 32;

    localparam int SHIFT_LEFT  = 5;
    localparam int SHIFT_RIGHT = 27;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/vrxh_if.sv =====
// Channel interfaces: input word stream and bucket result stream.
interface vrxh_in_if;
    import vrxh_pkg::*;

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element;
    logic              last_element;

    modport source (output valid, output element, output last_element, input ready);
    modport sink   (input valid, input element, input last_element, output ready);
endinterface

interface vrxh_out_if;
    import vrxh_pkg::*;

    logic                valid;
    logic                ready;
    logic [BUCKET_W-1:0] bucket;

    modport source (output valid, output bucket, input ready);
    modport sink   (input valid, input bucket, output ready);
endinterface

// ===== rtl/vrxh_div.sv =====
// Bit-serial restoring modulo unit: one compare-subtract per cycle.
module vrxh_div #(
    parameter int WORD_WIDTH = vrxh_pkg::DEF_WORD_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [WORD_WIDTH-1:0]        i_dividend,
    input  logic [vrxh_pkg::CAP_W-1:0]   i_modulus,
    output vrxh_pkg::t_div_stat          o_stat,
    output logic [vrxh_pkg::CAP_W-1:0]   o_rem
);
    import vrxh_pkg::*;

    localparam int CNT_W = $clog2(WORD_WIDTH);
    localparam int REM_W = CAP_W + 1;

    logic [WORD_WIDTH-1:0] r_dvd;
    logic [CAP_W-1:0]      r_mod;
    logic [CAP_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic [CAP_W-1:0] n_rem;

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_rem, r_dvd[WORD_WIDTH-1]};
    assign diff  = trial - {1'b0, r_mod};
    assign n_rem = (trial >= {1'b0, r_mod}) ? diff[CAP_W-1:0] : trial[CAP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_mod  <= i_modulus;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(WORD_WIDTH - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[WORD_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

// ===== rtl/vector_rotate_xor_hash_mod_top.sv =====
// Top level: running rotate-xor hash over a word stream, bucket index per vector.
//
//  channel      dir   handshake      payload
//  i_elem_ch    in    valid/ready    element[31:0], last_element
//  o_bucket_ch  out   valid/ready    bucket[30:0]
//  i_cfg_*      in    write enable   capacity[30:0]
//
// A word without the last flag is folded into the hash in a single step.
// For a last word the bucket comes from the bit-serial modulo unit, one dividend
// bit per cycle; input ready is low meanwhile.
// If the bucket register is still full when the modulo ends, input holds off
// until the result is taken. Reset is synchronous and clears the hash to zero.
`include "vector_rotate_xor_hash_mod_top_defines.svh"

module vector_rotate_xor_hash_mod_top #(
    parameter int WORD_WIDTH = vrxh_pkg::DEF_WORD_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    vrxh_in_if.sink                    i_elem_ch,
    vrxh_out_if.source                 o_bucket_ch,
    input  logic                       i_cfg_we,
    input  logic [vrxh_pkg::CAP_W-1:0] i_cfg_wdata
);
    import vrxh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                r_state;
    logic [WORD_WIDTH-1:0] r_hash;
    logic [CAP_W-1:0]      r_capacity;
    logic                  r_out_valid;
    logic [BUCKET_W-1:0]   r_bucket;

    logic [WORD_WIDTH-1:0] n_hash;
    logic [CAP_W-1:0]      cap_eff;
    logic [CAP_W-1:0]      modulus;
    logic                  in_xfer;
    logic                  div_start;
    logic                  out_free;
    logic                  bucket_load;
    t_div_stat             div_stat;
    logic [CAP_W-1:0]      div_rem;

    assign i_elem_ch.ready = (r_state == S_IDLE);
    assign in_xfer         = i_elem_ch.valid && i_elem_ch.ready;
    assign div_start       = in_xfer && i_elem_ch.last_element;
    assign out_free        = !r_out_valid || o_bucket_ch.ready;
    assign bucket_load     = out_free
                           && ((r_state == S_DIV && div_stat.done) || r_state == S_HOLD);

    assign n_hash = (r_hash << SHIFT_LEFT) ^ (r_hash >> SHIFT_RIGHT)
                  ^ WORD_WIDTH'(i_elem_ch.element);

    // capacity below two acts as two
    assign cap_eff = (r_capacity < CAP_MIN) ? CAP_MIN : r_capacity;
    assign modulus = cap_eff - 1'b1;

    vrxh_div #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_hash),
        .i_modulus  (modulus),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (bucket_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_bucket_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        // drop the hash once the vector ends
                        r_hash <= i_elem_ch.last_element ? '0 : n_hash;
                        if (i_elem_ch.last_element) begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        if (out_free) begin
                            r_bucket <= BUCKET_W'(div_rem);
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_bucket <= BUCKET_W'(div_rem);
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_bucket_ch.valid  = r_out_valid;
    assign o_bucket_ch.bucket = r_bucket;

    `VRXH_ASSERT_SAME(a_busy_blocks_input, i_clk, i_rst_n, div_stat.busy,
        !i_elem_ch.ready, "input ready while modulo unit busy")
    `VRXH_ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, div_stat.done,
        r_state == S_DIV, "modulo done outside divide state")
    `VRXH_ASSERT_NEXT(a_last_starts_div, i_clk, i_rst_n, div_start,
        div_stat.busy, "last word transfer did not start modulo")

endmodule
